/* sv/assert_macros.svh */
// Assertion macros shared by the checker files of the multiply-accumulate unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, with reset masking.
`define AMU_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("amu: implication check failed");

// Next-cycle implication, with reset masking.
`define AMU_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("amu: next-cycle check failed");

`endif

/* sv/amu_pkg.sv */
// Shared types, op codes and constants of the multiply-accumulate unit.
package amu_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned RegIdxWidth = 4;
   localparam int unsigned VerWidth    = 3;
   localparam int unsigned StatusWidth = 2;

   localparam logic [RegIdxWidth-1:0] PC_INDEX = 4'd15;

   // Architecture levels
   localparam logic [VerWidth-1:0] ARCH_V4    = 3'd4;
   localparam logic [VerWidth-1:0] ARCH_V6    = 3'd6;
   localparam logic [VerWidth-1:0] ARCH_RESET = 3'd7;

   // Op codes from instruction bits 23:20
   localparam logic [3:0] OP_MUL    = 4'b0000;
   localparam logic [3:0] OP_MULS   = 4'b0001;
   localparam logic [3:0] OP_MLA    = 4'b0010;
   localparam logic [3:0] OP_MLAS   = 4'b0011;
   localparam logic [3:0] OP_UMAAL  = 4'b0100;
   localparam logic [3:0] OP_UNDEF0 = 4'b0101;
   localparam logic [3:0] OP_MLS    = 4'b0110;
   localparam logic [3:0] OP_UNDEF1 = 4'b0111;

   // Status codes
   localparam logic [StatusWidth-1:0] ST_OK     = 2'd0;
   localparam logic [StatusWidth-1:0] ST_UNDEF  = 2'd1;
   localparam logic [StatusWidth-1:0] ST_NOIMP  = 2'd2;
   localparam logic [StatusWidth-1:0] ST_UNPRED = 2'd3;

   // Stream widths
   localparam int unsigned ReqDataWidth = 160;
   localparam int unsigned RspDataWidth = 80;

   typedef struct packed {
      logic [WordWidth-1:0] instruction_word;
      logic                 cond_pass;
      logic [WordWidth-1:0] operand_n;
      logic [WordWidth-1:0] operand_m;
      logic [WordWidth-1:0] accumulate_low;
      logic [WordWidth-1:0] accumulate_high;
   } amu_req_type;

   typedef struct packed {
      logic                   primary_write;
      logic [RegIdxWidth-1:0] primary_index;
      logic [WordWidth-1:0]   primary_value;
      logic                   secondary_write;
      logic [RegIdxWidth-1:0] secondary_index;
      logic [WordWidth-1:0]   secondary_value;
      logic                   flags_write;
      logic                   flag_negative;
      logic                   flag_zero;
      logic [StatusWidth-1:0] status;
   } amu_result_type;

endpackage

/* sv/arm_multiply_accumulate_unit.sv */
// Top level of the multiply-accumulate unit: stream ports, pipeline registers, CSR.
// A request is registered in the input stage, then its result in the result stage.
// Throughput: one instruction per cycle unless rsp_tready stalls; the single 33x33
// multiplier plus the 64-bit accumulate adder between the input and result registers
// set the cycle. Reset (synchronous, active high) empties both stages and sets the
// architecture level to 7; payload registers are not reset.
module arm_multiply_accumulate_unit
   import amu_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // req_tdata, low bit up: instruction_word[31:0], operand_n[63:32],
   // operand_m[95:64], accumulate_low[127:96], accumulate_high[159:128]
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,
   input  logic                    req_tuser,   // condition passed flag
   // rsp_tdata, low bit up: primary_write[0], primary_index[4:1],
   // primary_value[36:5], secondary_write[37], secondary_index[41:38],
   // secondary_value[73:42], flags_write[74], flag_negative[75],
   // flag_zero[76], zero fill[79:77]
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,
   output logic [StatusWidth-1:0]  rsp_tuser,   // status
   // architecture_version write port
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [VerWidth-1:0]     csr_data
);

   logic [VerWidth-1:0] arch_ff;
   logic [VerWidth-1:0] arch_in;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   amu_req_type         s1_req_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   amu_result_type      rsp_result_ff;
   amu_result_type      core_result;
   logic                rsp_advance;
   logic                s1_advance;
   logic                req_transfer;

   // The level register is always writable; write it only while nothing is in flight.
   assign csr_ready = 1'b1;
   assign arch_in   = (csr_valid && csr_ready) ? csr_data : arch_ff;

   // Result stage can load when empty or when its item is being taken.
   assign rsp_advance  = !rsp_valid_ff || rsp_tready;
   // Input stage moves on when it is empty or its item drops into the result stage.
   assign s1_advance   = !s1_valid_ff || rsp_advance;
   assign req_tready   = s1_advance;
   assign req_transfer = req_tvalid && req_tready;

   assign s1_valid_in  = s1_advance ? req_transfer : s1_valid_ff;
   assign rsp_valid_in = rsp_advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arch_ff      <= ARCH_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         arch_ff      <= arch_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the unpacked request on every input transfer.
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_req_ff.instruction_word <= req_tdata[31:0];
         s1_req_ff.operand_n        <= req_tdata[63:32];
         s1_req_ff.operand_m        <= req_tdata[95:64];
         s1_req_ff.accumulate_low   <= req_tdata[127:96];
         s1_req_ff.accumulate_high  <= req_tdata[159:128];
         s1_req_ff.cond_pass        <= req_tuser;
      end
   end

   amu_core u_core (
      .req        (s1_req_ff),
      .arch_level (arch_ff),
      .result     (core_result)
   );

   // Hold the result until the downstream side takes it.
   always_ff @(posedge clock) begin
      if (rsp_advance && s1_valid_ff) begin
         rsp_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_result_ff.status;
   assign rsp_tdata  = {3'b000,
                        rsp_result_ff.flag_zero,
                        rsp_result_ff.flag_negative,
                        rsp_result_ff.flags_write,
                        rsp_result_ff.secondary_value,
                        rsp_result_ff.secondary_index,
                        rsp_result_ff.secondary_write,
                        rsp_result_ff.primary_value,
                        rsp_result_ff.primary_index,
                        rsp_result_ff.primary_write};

endmodule

/* sv/amu_core.sv */
// Combinational decode, multiply-accumulate and status logic for one instruction.
module amu_core
   import amu_pkg::*;
(
   input  amu_req_type         req,
   input  logic [VerWidth-1:0] arch_level,
   output amu_result_type      result
);

   logic [3:0]             op;
   logic                   sbit;
   logic [RegIdxWidth-1:0] rhi;
   logic [RegIdxWidth-1:0] rlo;
   logic [RegIdxWidth-1:0] rm;
   logic [RegIdxWidth-1:0] rn;
   logic                   pre6;
   logic                   v4;
   logic                   is_long;
   logic                   sgn;
   logic signed [32:0]     mul_a;
   logic signed [32:0]     mul_b;
   logic signed [65:0]     product;
   logic [63:0]            prod64;
   logic [63:0]            long_res;
   logic [31:0]            short_res;
   logic                   short_setf;
   logic                   unp;

   assign op      = req.instruction_word[23:20];
   assign sbit    = op[0];
   assign rhi     = req.instruction_word[19:16];
   assign rlo     = req.instruction_word[15:12];
   assign rm      = req.instruction_word[11:8];
   assign rn      = req.instruction_word[3:0];
   assign pre6    = arch_level < ARCH_V6;
   assign v4      = arch_level == ARCH_V4;
   assign is_long = op[3];
   assign sgn     = op[3] & op[2];

   // One 33x33 signed multiplier covers both signed and unsigned forms.
   assign mul_a   = $signed({sgn & req.operand_n[31], req.operand_n});
   assign mul_b   = $signed({sgn & req.operand_m[31], req.operand_m});
   assign product = mul_a * mul_b;
   assign prod64  = product[63:0];

   assign long_res = prod64 +
      (op[1] ? {req.accumulate_high, req.accumulate_low} : 64'd0);

   always_comb begin
      case (op) inside
         OP_MLA, OP_MLAS: short_res = prod64[31:0] + req.accumulate_low;
         OP_MLS:          short_res = req.accumulate_low - prod64[31:0];
         default:         short_res = prod64[31:0];
      endcase
   end

   assign short_setf = sbit & ~op[2];

   always_comb begin
      unp = (rhi == PC_INDEX) || (rn == PC_INDEX) || (rm == PC_INDEX);
      if (is_long) begin
         if ((rlo == PC_INDEX) || (rhi == rlo)) unp = 1'b1;
         if (pre6 && ((rhi == rn) || (rlo == rn))) unp = 1'b1;
         if (sbit && v4) unp = 1'b1;
      end else begin
         if (op != OP_MUL && op != OP_MULS && rlo == PC_INDEX) unp = 1'b1;
         if (op != OP_MLS && pre6 && rhi == rn) unp = 1'b1;
         if (short_setf && v4) unp = 1'b1;
      end
   end

   always_comb begin
      result = '0;
      if (op == OP_UNDEF0 || op == OP_UNDEF1) begin
         result.status = ST_UNDEF;
      end else if (op == OP_UMAAL) begin
         result.status = ST_NOIMP;
      end else if (req.cond_pass) begin
         result.primary_write = 1'b1;
         result.status        = unp ? ST_UNPRED : ST_OK;
         if (is_long) begin
            result.primary_index   = rlo;
            result.primary_value   = long_res[31:0];
            result.secondary_write = 1'b1;
            result.secondary_index = rhi;
            result.secondary_value = long_res[63:32];
            if (sbit) begin
               result.flags_write   = 1'b1;
               result.flag_negative = long_res[63];
               result.flag_zero     = long_res == 64'd0;
            end
         end else begin
            result.primary_index = rhi;
            result.primary_value = short_res;
            if (short_setf) begin
               result.flags_write   = 1'b1;
               result.flag_negative = short_res[31];
               result.flag_zero     = short_res == 32'd0;
            end
         end
      end
   end

endmodule

/* sv/amu_checker.sv */
// Port-level checker for the multiply-accumulate unit, bound to the top level.
`include "assert_macros.svh"

module amu_checker
   import amu_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata,
   input logic [StatusWidth-1:0]  rsp_tuser
);

   logic fault_rsp;
   logic fresh_req;

   // Result offered with a fault status; input taken while the result side is empty.
   assign fault_rsp = rsp_tvalid && (rsp_tuser == ST_UNDEF || rsp_tuser == ST_NOIMP);
   assign fresh_req = req_tvalid && req_tready && !rsp_tvalid;

   `AMU_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   `AMU_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   `AMU_ASSERT_IMP(a_fault_no_write, clock, reset, fault_rsp, rsp_tdata == '0)

   `AMU_ASSERT_IMP(a_hi_needs_lo, clock, reset, rsp_tvalid && rsp_tdata[37], rsp_tdata[0])

   `AMU_ASSERT_NXT(a_in_reaches_out, clock, reset, fresh_req, ##1 rsp_tvalid)

endmodule

bind arm_multiply_accumulate_unit amu_checker u_amu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* tb/testbench.sv */
// Self-checking testbench of the ARM multiply-accumulate unit: stream stimulus and result checks.
`timescale 1ns / 100ps

module testbench
   import amu_pkg::*;
();

   // Long-op encodings (bit 3 set), and the op bits that steer them
   localparam logic [3:0] OP_UMULL = 4'b1000;
   localparam logic [3:0] OP_UMLAL = 4'b1010;
   localparam logic [3:0] OP_SMULL = 4'b1100;
   localparam logic [3:0] OP_SMLAL = 4'b1110;
   localparam int unsigned LongBit   = 3;
   localparam int unsigned SignedBit = 2;
   localparam int unsigned AccumBit  = 1;
   localparam int unsigned SetFlagsBit = 0;

   localparam logic [3:0] MulTag     = 4'b1001;   // bits 7:4 of the multiply group
   localparam logic [3:0] CondAlways = 4'hE;
   localparam int unsigned Latency   = 2;
   localparam int unsigned IdleLimit = 2000;
   localparam int unsigned PhaseItems = 200;

   // Work out the register writes, flag update and status of one instruction.
   function automatic amu_result_type predict_mac(amu_req_type r, logic [VerWidth-1:0] arch);
      logic [3:0] op, rhi, rlo, rm, rn;
      logic sbit, pre6, v4, unp, setf;
      logic [31:0] prod, word;
      logic [63:0] a64, b64, wide;
      amu_result_type e;
      e = '0;
      op = r.instruction_word[23:20];
      rhi = r.instruction_word[19:16];
      rlo = r.instruction_word[15:12];
      rm = r.instruction_word[11:8];
      rn = r.instruction_word[3:0];
      sbit = op[SetFlagsBit];
      pre6 = arch < ARCH_V6;
      v4 = arch == ARCH_V4;
      if (op == OP_UNDEF0 || op == OP_UNDEF1) begin
         e.status = ST_UNDEF;
         return e;
      end
      if (op == OP_UMAAL) begin
         e.status = ST_NOIMP;
         return e;
      end
      if (!r.cond_pass)
         return e;
      unp = (rhi == PC_INDEX) || (rn == PC_INDEX) || (rm == PC_INDEX);
      if (!op[LongBit]) begin
         prod = r.operand_n * r.operand_m;
         if (op == OP_MUL || op == OP_MULS) begin
            word = prod;
            setf = sbit;
         end else if (op == OP_MLA || op == OP_MLAS) begin
            word = prod + r.accumulate_low;
            setf = sbit;
            unp |= rlo == PC_INDEX;
         end else begin
            word = r.accumulate_low - prod;
            setf = 1'b0;
            unp |= rlo == PC_INDEX;
         end
         if (op != OP_MLS && pre6 && rhi == rn)
            unp = 1'b1;
         if (setf && v4)
            unp = 1'b1;
         e.primary_write = 1'b1;
         e.primary_index = rhi;
         e.primary_value = word;
         if (setf) begin
            e.flags_write = 1'b1;
            e.flag_negative = word[31];
            e.flag_zero = word == 32'd0;
         end
      end else begin
         a64 = op[SignedBit] ? {{32{r.operand_n[31]}}, r.operand_n} : {32'd0, r.operand_n};
         b64 = op[SignedBit] ? {{32{r.operand_m[31]}}, r.operand_m} : {32'd0, r.operand_m};
         wide = a64 * b64;
         if (op[AccumBit])
            wide = wide + {r.accumulate_high, r.accumulate_low};
         if (rlo == PC_INDEX || rhi == rlo)
            unp = 1'b1;
         if (pre6 && (rhi == rn || rlo == rn))
            unp = 1'b1;
         if (sbit && v4)
            unp = 1'b1;
         e.primary_write = 1'b1;
         e.primary_index = rlo;
         e.primary_value = wide[31:0];
         e.secondary_write = 1'b1;
         e.secondary_index = rhi;
         e.secondary_value = wide[63:32];
         if (sbit) begin
            e.flags_write = 1'b1;
            e.flag_negative = wide[63];
            e.flag_zero = wide == 64'd0;
         end
      end
      e.status = unp ? ST_UNPRED : ST_OK;
      return e;
   endfunction

   // Holds the architecture level and the results still owed by the block.
   class mac_expectations;
      amu_result_type owed[$];
      logic [VerWidth-1:0] arch_level = ARCH_RESET;
      int mismatches = 0;

      function int pending();
         return owed.size();
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %h, want %h", name, got, want));
      endtask

      task note_instruction(amu_req_type r);
         owed.push_back(predict_mac(r, arch_level));
      endtask

      task check_result(logic [RspDataWidth-1:0] data, logic [StatusWidth-1:0] status);
         amu_result_type want;
         if (owed.size() == 0) begin
            report_mismatch("result with no instruction outstanding");
            return;
         end
         want = owed.pop_front();
         compare_field("primary_write", 32'(data[0]), 32'(want.primary_write));
         compare_field("primary_index", 32'(data[4:1]), 32'(want.primary_index));
         compare_field("primary_value", data[36:5], want.primary_value);
         compare_field("secondary_write", 32'(data[37]), 32'(want.secondary_write));
         compare_field("secondary_index", 32'(data[41:38]), 32'(want.secondary_index));
         compare_field("secondary_value", data[73:42], want.secondary_value);
         compare_field("flags_write", 32'(data[74]), 32'(want.flags_write));
         compare_field("flag_negative", 32'(data[75]), 32'(want.flag_negative));
         compare_field("flag_zero", 32'(data[76]), 32'(want.flag_zero));
         compare_field("status", 32'(status), 32'(want.status));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic [StatusWidth-1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [VerWidth-1:0] csr_data = '0;

   // While calm is set, neither side idles: back-to-back transfers.
   bit calm = 1'b0;
   int unsigned stall_left = 0;
   int unsigned idle_cycles = 0;
   mac_expectations ledger = new();

   arm_multiply_accumulate_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int unsigned stall_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return $urandom_range(0, 2);
      else if (pick < 95)
         return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   // Back-pressure on the result side: drop tready for random stretches.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_length();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check every result transfer against the oldest owed result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_result(rsp_tdata, rsp_tuser);
   end

   // End the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
            || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [31:0] make_word(logic [3:0] op, logic [3:0] rhi, logic [3:0] rlo,
                                            logic [3:0] rm, logic [3:0] rn);
      return {CondAlways, 4'b0000, op, rhi, rlo, rm, MulTag, rn};
   endfunction

   // Present one instruction, keeping tvalid high across back-to-back transfers,
   // and note it at the edge where the transfer completes.
   task automatic send_item(amu_req_type r);
      int unsigned gap;
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : stall_length();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r.accumulate_high, r.accumulate_low, r.operand_m, r.operand_n,
                    r.instruction_word};
      req_tuser <= r.cond_pass;
      do @(posedge clock); while (!req_tready);
      ledger.note_instruction(r);
   endtask

   task automatic send_fields(logic [31:0] word, logic cond, logic [31:0] n, logic [31:0] m,
                              logic [31:0] lo, logic [31:0] hi);
      amu_req_type r;
      r.instruction_word = word;
      r.cond_pass = cond;
      r.operand_n = n;
      r.operand_m = m;
      r.accumulate_low = lo;
      r.accumulate_high = hi;
      send_item(r);
   endtask

   // Drain the block, then write the architecture level.
   task automatic write_arch(logic [VerWidth-1:0] level);
      req_tvalid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= level;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ledger.arch_level = level;
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [3:0] pick_reg();
      return ($urandom_range(0, 7) == 0) ? PC_INDEX : 4'($urandom_range(0, 14));
   endfunction

   // Random instruction of the multiply group, with register clashes made likely.
   function automatic amu_req_type random_request();
      amu_req_type r;
      logic [3:0] rhi, rlo, rn;
      rhi = pick_reg();
      rlo = pick_reg();
      rn = pick_reg();
      if ($urandom_range(0, 3) == 0)
         rlo = rhi;
      case ($urandom_range(0, 5))
         0: rn = rhi;
         1: rn = rlo;
         default: ;
      endcase
      r.instruction_word = {8'($urandom), 4'($urandom_range(0, 15)), rhi, rlo, pick_reg(),
                            ($urandom_range(0, 9) == 0) ? 4'($urandom) : MulTag, rn};
      r.cond_pass = $urandom_range(0, 99) < 85;
      r.operand_n = pick_operand();
      r.operand_m = pick_operand();
      r.accumulate_low = pick_operand();
      r.accumulate_high = pick_operand();
      return r;
   endfunction

   task automatic run_random(int unsigned count);
      repeat (count) send_item(random_request());
   endtask

   initial begin
      logic [31:0] word;
      logic [VerWidth-1:0] levels[7];
      levels = '{ARCH_RESET, 3'd5, ARCH_V4, ARCH_V6, 3'd0, 3'd3, ARCH_RESET};

      // Hold reset, then release it once.
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset level: every op but flag-setting UMLAL, operand extremes,
      // flags, failed condition, undefined ops, UMAAL and the PC/overlap rules.
      send_fields(make_word(OP_MUL, 4'd1, 4'd0, 4'd3, 4'd2), 1'b1,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_fields(make_word(OP_MULS, 4'd1, 4'd0, 4'd3, 4'd2), 1'b1,
                  32'd0, 32'h1234_5678, 32'd0, 32'd0);
      send_fields(make_word(OP_MLAS, 4'd4, 4'd5, 4'd6, 4'd7), 1'b1,
                  32'h8000_0000, 32'd1, 32'd0, 32'd0);
      send_fields(make_word(OP_MLAS, 4'd4, 4'd5, 4'd6, 4'd7), 1'b1,
                  32'd1, 32'd1, 32'hFFFF_FFFF, 32'd0);
      send_fields(make_word(OP_MLS, 4'd8, 4'd9, 4'd10, 4'd11), 1'b1,
                  32'd3, 32'd5, 32'd0, 32'd0);
      send_fields(make_word(OP_UMULL | 4'b0001, 4'd1, 4'd2, 4'd3, 4'd4), 1'b1,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_fields(make_word(OP_UMLAL, 4'd1, 4'd2, 4'd3, 4'd4), 1'b1,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_fields(make_word(OP_SMULL | 4'b0001, 4'd5, 4'd6, 4'd7, 4'd8), 1'b1,
                  32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
      send_fields(make_word(OP_SMLAL | 4'b0001, 4'd5, 4'd6, 4'd7, 4'd8), 1'b1,
                  32'hFFFF_FFFF, 32'd1, 32'd1, 32'd0);
      send_fields(make_word(OP_SMULL, 4'd5, 4'd6, 4'd7, 4'd8), 1'b1,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0);
      send_fields(make_word(OP_UMAAL, 4'd1, 4'd2, 4'd3, 4'd4), 1'b1,
                  32'd7, 32'd9, 32'd1, 32'd2);
      send_fields(make_word(OP_UNDEF0, 4'd1, 4'd2, 4'd3, 4'd4), 1'b0,
                  32'd7, 32'd9, 32'd1, 32'd2);
      send_fields(make_word(OP_UNDEF1, 4'd1, 4'd2, 4'd3, 4'd4), 1'b1,
                  32'd7, 32'd9, 32'd1, 32'd2);
      send_fields(make_word(OP_MUL, 4'd1, 4'd0, 4'd3, 4'd2), 1'b0,
                  32'd7, 32'd9, 32'd0, 32'd0);
      send_fields(make_word(OP_MUL, PC_INDEX, 4'd0, 4'd3, 4'd2), 1'b1,
                  32'd7, 32'd9, 32'd0, 32'd0);
      send_fields(make_word(OP_MLA, 4'd1, PC_INDEX, 4'd3, 4'd2), 1'b1,
                  32'd7, 32'd9, 32'd5, 32'd0);
      send_fields(make_word(OP_UMULL, 4'd6, 4'd6, 4'd3, 4'd2), 1'b1,
                  32'd7, 32'd9, 32'd0, 32'd0);
      send_fields(make_word(OP_SMLAL, 4'd1, 4'd2, PC_INDEX, PC_INDEX), 1'b1,
                  32'hFFFF_FFFE, 32'd3, 32'd4, 32'd5);
      // Encoding bits outside the op and registers are ignored.
      word = make_word(OP_MUL, 4'd1, PC_INDEX, 4'd3, 4'd2);
      word[31:24] = 8'hFF;
      word[7:4] = 4'b0000;
      send_fields(word, 1'b1, 32'd6, 32'd7, 32'd0, 32'd0);

      // Directed part at level 4: flag-setting and overlap restrictions.
      write_arch(ARCH_V4);
      send_fields(make_word(OP_MULS, 4'd1, 4'd0, 4'd3, 4'd2), 1'b1,
                  32'd2, 32'd3, 32'd0, 32'd0);
      send_fields(make_word(OP_MLS, 4'd2, 4'd0, 4'd3, 4'd2), 1'b1,
                  32'd2, 32'd3, 32'd9, 32'd0);
      send_fields(make_word(OP_UMLAL | 4'b0001, 4'd1, 4'd2, 4'd3, 4'd2), 1'b1,
                  32'd2, 32'd3, 32'd4, 32'd5);
      send_fields(make_word(OP_MUL, 4'd2, 4'd0, 4'd3, 4'd2), 1'b1,
                  32'd2, 32'd3, 32'd0, 32'd0);
      send_fields(make_word(OP_UMULL, 4'd1, 4'd2, 4'd3, 4'd4), 1'b1,
                  32'd2, 32'd3, 32'd0, 32'd0);

      // Random phases, each at a level from the list; some run with no idling at all.
      foreach (levels[i]) begin
         write_arch(levels[i]);
         calm = $urandom_range(0, 3) == 0;
         run_random(PhaseItems);
      end
      calm = 1'b0;

      // Drain, then wait for any stray result.
      req_tvalid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (Latency + 6) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
